### rtl/zcpt_pkg.sv
`default_nettype none
package zcpt_pkg;

    // field widths
    localparam int unsigned LEVEL_W  = 12;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned PERIOD_W = 20;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CMD_W    = 2;
    localparam int unsigned CFG_W    = 20;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned S_DATA_W = 88;
    localparam int unsigned S_USER_W = 2;
    localparam int unsigned M_DATA_W = 128;
    localparam int unsigned M_USER_W = 2;

    // command codes on the input side
    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MARK   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PACKET = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LEVEL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_US    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_START = 2'd3;

    // register reset values
    localparam logic [LEVEL_W-1:0]  ZERO_LEVEL_RST   = 12'd1982;
    localparam logic [PERIOD_W-1:0] PERIOD_US_RST    = 20'd20000;
    localparam logic [BYTE_W-1:0]   HEADER_BYTE_RST  = 8'hAA;
    localparam logic [LEVEL_W-1:0]  WINDOW_START_RST = 12'd2048;

    // classified request kinds
    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_MARK   = 2'd1,
        KIND_PACKET = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    // request handed from front to back
    typedef struct packed {
        kind_t               kind;
        logic [LEVEL_W-1:0]  sample;
        logic [TIME_W-1:0]   time_us;
    } req_t;

    // result item
    typedef struct packed {
        logic [LEVEL_W-1:0]  filtered;
        logic                crossing;
        logic [TIME_W-1:0]   crossing_interval;
        logic                packet_ok;
        logic [PERIOD_W-1:0] phase_offset;
        logic [TIME_W-1:0]   whole_periods;
        logic [TIME_W-1:0]   latency_us;
    } res_t;

    // divider start request
    typedef struct packed {
        logic                start;
        logic [TIME_W-1:0]   dividend;
        logic [PERIOD_W-1:0] divisor;
    } div_req_t;

    // divider response
    typedef struct packed {
        logic                done;
        logic [TIME_W-1:0]   quotient;
        logic [PERIOD_W-1:0] remainder;
    } div_rsp_t;

endpackage
`default_nettype wire

### rtl/zcpt_div.sv
`default_nettype none
module zcpt_div
    import zcpt_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    localparam int unsigned CNT_W = $clog2(TIME_W);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [TIME_W-1:0]   quo_reg, quo_next;
    logic [PERIOD_W-1:0] rem_reg, rem_next;
    logic [PERIOD_W-1:0] dsr_reg, dsr_next;
    logic [PERIOD_W:0]   rem_shift;
    logic [PERIOD_W:0]   rem_diff;
    logic                fits;

    // one restoring step per cycle, quotient bits shift in from the right
    assign rem_shift = {rem_reg, quo_reg[TIME_W-1]};
    assign rem_diff  = rem_shift - {1'b0, dsr_reg};
    assign fits      = (rem_shift >= {1'b0, dsr_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[TIME_W-2:0], fits};
            rem_next = fits ? rem_diff[PERIOD_W-1:0] : rem_shift[PERIOD_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(TIME_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule
`default_nettype wire

### rtl/zcpt_front.sv
`default_nettype none
module zcpt_front
    import zcpt_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic [BYTE_W-1:0]   header_byte,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,
    input  wire logic [S_USER_W-1:0] s_tuser,
    output logic                     q_valid,
    input  wire logic                q_ready,
    output req_t                     q_req
);

    localparam int unsigned DEPTH = 2;

    logic [BYTE_W-1:0] b0, b1, b2, b3, b4;
    logic [BYTE_W-1:0] byte_sum;
    logic              pkt_good;
    req_t              in_req;
    req_t              q_mem_reg [DEPTH];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        count_reg, count_next;
    logic              push, pop;

    // unpack the packet bytes
    assign b0 = s_tdata[44 +: BYTE_W];
    assign b1 = s_tdata[52 +: BYTE_W];
    assign b2 = s_tdata[60 +: BYTE_W];
    assign b3 = s_tdata[68 +: BYTE_W];
    assign b4 = s_tdata[76 +: BYTE_W];

    // header and checksum check
    assign byte_sum = b0 + b1 + b2 + b3;
    assign pkt_good = (b0 == header_byte) && (byte_sum == b4);

    // classify the request
    always_comb begin
        in_req.sample  = s_tdata[0 +: LEVEL_W];
        in_req.time_us = s_tdata[LEVEL_W +: TIME_W];
        case (s_tuser)
            CMD_SAMPLE: in_req.kind = KIND_SAMPLE;
            CMD_MARK:   in_req.kind = KIND_MARK;
            CMD_PACKET: in_req.kind = pkt_good ? KIND_PACKET : KIND_NONE;
            default:    in_req.kind = KIND_NONE;
        endcase
    end

    // two-entry queue toward the back end
    assign s_tready = (count_reg != 2'(DEPTH));
    assign q_valid  = (count_reg != 2'd0);
    assign q_req    = q_mem_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= in_req;
        end
    end

endmodule
`default_nettype wire

### rtl/zcpt_back.sv
`default_nettype none
module zcpt_back
    import zcpt_pkg::*;
#(
    parameter int unsigned TAPS = 5
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic [LEVEL_W-1:0]  zero_level,
    input  wire logic [PERIOD_W-1:0] period_us,
    input  wire logic                preset,
    input  wire logic [LEVEL_W-1:0]  preset_value,
    input  wire logic                q_valid,
    output logic                     q_ready,
    input  wire req_t                q_req,
    output div_req_t                 div_req,
    input  wire div_rsp_t            div_rsp,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output res_t                     out_res
);

    localparam int unsigned SUM_W  = LEVEL_W + $clog2(TAPS);
    localparam int unsigned SLOT_W = (TAPS > 1) ? $clog2(TAPS) : 1;
    // exact divide by TAPS: floor(sum * ceil(2^K / TAPS) / 2^K)
    localparam int unsigned AVG_K  = SUM_W + $clog2(TAPS);
    localparam longint unsigned AVG_M = ((64'd1 << AVG_K) + 64'(TAPS) - 64'd1) / 64'(TAPS);
    localparam int unsigned PROD_W = SUM_W + AVG_K + 1;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_AVG   = 5'b00010,
        ST_CROSS = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [LEVEL_W-1:0]  window_reg [TAPS];
    logic [LEVEL_W-1:0]  window_next [TAPS];
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [LEVEL_W-1:0]  avg_reg, avg_next;
    logic [LEVEL_W-1:0]  prev_reg, prev_next;
    logic [TIME_W-1:0]   last_cross_reg, last_cross_next;
    logic [TIME_W-1:0]   gap_reg, gap_next;
    logic [TIME_W-1:0]   mark_reg, mark_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic                cross_reg, cross_next;
    logic                ok_reg, ok_next;
    logic [PERIOD_W-1:0] phase_reg, phase_next;
    logic [TIME_W-1:0]   periods_reg, periods_next;
    logic [TIME_W-1:0]   lat_reg, lat_next;
    logic                period_zero_reg, period_zero_next;
    logic                out_valid_reg, out_valid_next;
    res_t                out_res_reg, out_res_next;
    logic [PROD_W-1:0]   avg_prod;
    logic                out_free;

    // registered sum times the reciprocal
    assign avg_prod = PROD_W'(sum_reg) * PROD_W'(AVG_M);
    assign out_free = !out_valid_reg || out_ready;
    assign q_ready  = (state_reg == ST_IDLE);

    always_comb begin
        state_next       = state_reg;
        window_next      = window_reg;
        sum_next         = sum_reg;
        slot_next        = slot_reg;
        avg_next         = avg_reg;
        prev_next        = prev_reg;
        last_cross_next  = last_cross_reg;
        gap_next         = gap_reg;
        mark_next        = mark_reg;
        now_next         = now_reg;
        cross_next       = cross_reg;
        ok_next          = ok_reg;
        phase_next       = phase_reg;
        periods_next     = periods_reg;
        lat_next         = lat_reg;
        period_zero_next = period_zero_reg;
        out_res_next     = out_res_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        div_req.start    = 1'b0;
        div_req.dividend = q_req.time_us - last_cross_reg;
        div_req.divisor  = period_us;

        case (state_reg)
            // take a request and start its work
            ST_IDLE: begin
                if (q_valid) begin
                    cross_next   = 1'b0;
                    ok_next      = 1'b0;
                    phase_next   = '0;
                    periods_next = '0;
                    lat_next     = '0;
                    now_next     = q_req.time_us;
                    case (q_req.kind)
                        KIND_SAMPLE: begin
                            sum_next = sum_reg - SUM_W'(window_reg[slot_reg])
                                       + SUM_W'(q_req.sample);
                            window_next[slot_reg] = q_req.sample;
                            slot_next  = (slot_reg == SLOT_W'(TAPS - 1)) ? '0
                                                                          : slot_reg + 1'b1;
                            state_next = ST_AVG;
                        end
                        KIND_MARK: begin
                            mark_next  = q_req.time_us;
                            state_next = ST_DONE;
                        end
                        KIND_PACKET: begin
                            ok_next          = 1'b1;
                            lat_next         = q_req.time_us - mark_reg;
                            period_zero_next = (period_us == '0);
                            div_req.start    = 1'b1;
                            state_next       = ST_DIV;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            // new moving average
            ST_AVG: begin
                avg_next   = avg_prod[AVG_K +: LEVEL_W];
                state_next = ST_CROSS;
            end
            // rising crossing of the zero level
            ST_CROSS: begin
                if ((avg_reg != '0) && (prev_reg != '0) && (prev_reg <= zero_level)
                    && (avg_reg > zero_level)) begin
                    cross_next      = 1'b1;
                    gap_next        = now_reg - last_cross_reg;
                    last_cross_next = now_reg;
                end
                prev_next  = avg_reg;
                state_next = ST_DONE;
            end
            // phase and whole periods from the divider
            ST_DIV: begin
                if (div_rsp.done) begin
                    phase_next   = period_zero_reg ? '0 : div_rsp.remainder;
                    periods_next = div_rsp.quotient;
                    state_next   = ST_DONE;
                end
            end
            // hand the result to the output register
            ST_DONE: begin
                if (out_free) begin
                    out_res_next.filtered          = avg_reg;
                    out_res_next.crossing          = cross_reg;
                    out_res_next.crossing_interval = gap_reg;
                    out_res_next.packet_ok         = ok_reg;
                    out_res_next.phase_offset      = phase_reg;
                    out_res_next.whole_periods     = periods_reg;
                    out_res_next.latency_us        = lat_reg;
                    out_valid_next                 = 1'b1;
                    state_next                     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // window refill on a window_start write
        if (preset) begin
            for (int i = 0; i < int'(TAPS); i++) begin
                window_next[i] = preset_value;
            end
            sum_next  = SUM_W'(TAPS) * SUM_W'(preset_value);
            slot_next = '0;
            avg_next  = preset_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            for (int i = 0; i < int'(TAPS); i++) begin
                window_reg[i] <= WINDOW_START_RST;
            end
            sum_reg        <= SUM_W'(TAPS) * SUM_W'(WINDOW_START_RST);
            slot_reg       <= '0;
            avg_reg        <= WINDOW_START_RST;
            prev_reg       <= '0;
            last_cross_reg <= '0;
            gap_reg        <= '0;
            mark_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            window_reg     <= window_next;
            sum_reg        <= sum_next;
            slot_reg       <= slot_next;
            avg_reg        <= avg_next;
            prev_reg       <= prev_next;
            last_cross_reg <= last_cross_next;
            gap_reg        <= gap_next;
            mark_reg       <= mark_next;
            out_valid_reg  <= out_valid_next;
        end
        now_reg         <= now_next;
        cross_reg       <= cross_next;
        ok_reg          <= ok_next;
        phase_reg       <= phase_next;
        periods_reg     <= periods_next;
        lat_reg         <= lat_next;
        period_zero_reg <= period_zero_next;
        out_res_reg     <= out_res_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule
`default_nettype wire

### rtl/zero_crossing_phase_timer.sv
// channel  dir  handshake              payload
// s_       in   s_tvalid / s_tready    s_tdata (88 bits), s_tuser (command)
// m_       out  m_tvalid / m_tready    m_tdata (128 bits), m_tuser (flags)
// cfg_     in   cfg_valid / cfg_ready  cfg_index (2 bits), cfg_data (20 bits)
//
// a sample request goes through the average and crossing states, a transmit
// mark or ignored request to done, a good packet to the 32-step divider
// reset is synchronous on aresetn low: registers to defaults, window preset
// a two-entry request queue lets the input keep accepting while the back end
// works or m_tready holds the output, until full; cfg_ready is always high
`default_nettype none
module zero_crossing_phase_timer
    import zcpt_pkg::*;
#(
    parameter int unsigned TAPS = 5
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // sample[11:0], time_us[43:12], byte_zero[51:44], byte_one[59:52],
    // byte_two[67:60], byte_three[75:68], byte_four[83:76], zero fill
    input  wire logic [S_DATA_W-1:0]  s_tdata,
    // command[1:0]
    input  wire logic [S_USER_W-1:0]  s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // filtered[11:0], crossing_interval[43:12], phase_offset[63:44],
    // whole_periods[95:64], latency_us[127:96]
    output logic [M_DATA_W-1:0]       m_tdata,
    // crossing[0], packet_ok[1]
    output logic [M_USER_W-1:0]       m_tuser,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    logic [LEVEL_W-1:0]  zero_level_reg;
    logic [PERIOD_W-1:0] period_us_reg;
    logic [BYTE_W-1:0]   header_byte_reg;
    logic                cfg_write;
    logic                preset;
    logic                q_valid, q_ready;
    req_t                q_req;
    div_req_t            div_req;
    div_rsp_t            div_rsp;
    res_t                out_res;

    // register writes
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign preset    = cfg_write && (cfg_index == CFG_WINDOW_START);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_level_reg  <= ZERO_LEVEL_RST;
            period_us_reg   <= PERIOD_US_RST;
            header_byte_reg <= HEADER_BYTE_RST;
        end else if (cfg_write) begin
            case (cfg_index)
                CFG_ZERO_LEVEL:  zero_level_reg  <= cfg_data[LEVEL_W-1:0];
                CFG_PERIOD_US:   period_us_reg   <= cfg_data[PERIOD_W-1:0];
                CFG_HEADER_BYTE: header_byte_reg <= cfg_data[BYTE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // request classification and queue
    zcpt_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .header_byte (header_byte_reg),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_req       (q_req)
    );

    // filter, crossing tracking and result register
    zcpt_back #(
        .TAPS (TAPS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .zero_level   (zero_level_reg),
        .period_us    (period_us_reg),
        .preset       (preset),
        .preset_value (cfg_data[LEVEL_W-1:0]),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_req        (q_req),
        .div_req      (div_req),
        .div_rsp      (div_rsp),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_res      (out_res)
    );

    // elapsed time over the period
    zcpt_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // result packing
    assign m_tdata = {out_res.latency_us, out_res.whole_periods, out_res.phase_offset,
                      out_res.crossing_interval, out_res.filtered};
    assign m_tuser = {out_res.packet_ok, out_res.crossing};

endmodule
`default_nettype wire
